@@ rtl/core/positional_list_engine_macros.svh @@
// Assertion macros for the positional list engine.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/ple_pkg.sv @@
// Package for the positional list engine: sizes, action and status codes,
// and the structs passed between the sequencer, the store and the top level.
// No dependencies.
package ple_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned PCMP_W   = POS_W + 1;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned COUNT_W  = 6;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [STAT_W-1:0]        stat_t;

  localparam logic [ACT_W-1:0] ACT_INS_FIRST = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_LAST  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_AT    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_FIRST = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEL_LAST  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DEL_AT    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_READ_ALL  = 3'd6;

  localparam stat_t ST_OK     = 2'd0;
  localparam stat_t ST_BADPOS = 2'd1;
  localparam stat_t ST_FULL   = 2'd2;
  localparam stat_t ST_EMPTY  = 2'd3;

  // One write port and one read port per cycle.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  // Result handed to the output register.
  typedef struct packed {
    logic               vld;
    stat_t              status;
    data_t              element;
    logic [COUNT_W-1:0] count;
    logic               last;
  } res_t;

endpackage

@@ rtl/core/ple_store.sv @@
// Element store of the positional list engine: one write and one read port,
// registered read data. Depends on ple_pkg.
module ple_store import ple_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output data_t    rdata_o
);

  data_t mem [CAPACITY];
  data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/ple_ctrl.sv @@
// Sequencer of the positional list engine: decodes a request, steps one
// pointer unit through the store to shift or read out, and issues results.
// Depends on ple_pkg.
module ple_ctrl import ple_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ACT_W-1:0] action_i,
  input  data_t            value_i,
  input  logic [POS_W-1:0] position_i,
  input  logic             out_free_i,
  output res_t             res_o,
  output mem_req_t         mem_o,
  input  data_t            rdata_i,
  output cnt_t             cnt_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_RREQ  = 3'd4;
  localparam logic [2:0] S_RDATA = 3'd5;

  logic [2:0] state_q, state_d;
  cnt_t       cnt_q, cnt_d;
  logic       more_q, more_d;
  logic       wv_q, wv_d;
  addr_t      ptr_q, ptr_d;
  addr_t      stop_q, stop_d;
  addr_t      wa_q, wa_d;
  addr_t      idx_q, idx_d;
  logic       ins_q, ins_d;
  data_t      val_q, val_d;
  stat_t      stat_q, stat_d;

  logic              accept;
  logic              full, empty;
  logic [PCMP_W-1:0] pos_ext, cnt_ext;
  logic              ins_pos_ok, del_pos_ok;
  addr_t             pos_idx, cnt_low, cnt_m1;
  addr_t             ptr_inc, ptr_dec;
  logic              rd_last;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign full       = (cnt_q == CNT_W'(CAPACITY));
  assign empty      = (cnt_q == '0);
  assign pos_ext    = {1'b0, position_i};
  assign cnt_ext    = PCMP_W'(cnt_q);
  assign ins_pos_ok = (position_i != '0) && (pos_ext <= cnt_ext + PCMP_W'(1));
  assign del_pos_ok = (position_i != '0) && (pos_ext <= cnt_ext);
  assign pos_idx    = ADDR_W'(position_i - POS_W'(1));
  assign cnt_low    = ADDR_W'(cnt_q);
  assign cnt_m1     = ADDR_W'(cnt_q - CNT_W'(1));
  assign ptr_inc    = ptr_q + ADDR_W'(1);
  assign ptr_dec    = ptr_q - ADDR_W'(1);
  assign rd_last    = (CNT_W'(ptr_q) + CNT_W'(1) == cnt_q);
  assign cnt_o      = cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    more_d  = more_q;
    wv_d    = wv_q;
    ptr_d   = ptr_q;
    stop_d  = stop_q;
    wa_d    = wa_q;
    idx_d   = idx_q;
    ins_d   = ins_q;
    val_d   = val_q;
    stat_d  = stat_q;
    mem_o   = '0;
    res_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d  = value_i;
          stat_d = ST_OK;
          state_d = S_EMIT;
          case (action_i)
            ACT_INS_FIRST, ACT_INS_LAST, ACT_INS_AT: begin
              if (full) begin
                stat_d = ST_FULL;
              end else if (action_i == ACT_INS_AT && !ins_pos_ok) begin
                stat_d = ST_BADPOS;
              end else begin
                ins_d = 1'b1;
                if (action_i == ACT_INS_FIRST) begin
                  idx_d = '0;
                end else if (action_i == ACT_INS_LAST) begin
                  idx_d = cnt_low;
                end else begin
                  idx_d = pos_idx;
                end
                if (CNT_W'(idx_d) == cnt_q) begin
                  state_d = S_PUT;
                end else begin
                  // Move the tail up by one, from the end down to the slot.
                  ptr_d   = cnt_m1;
                  stop_d  = idx_d;
                  more_d  = 1'b1;
                  wv_d    = 1'b0;
                  state_d = S_SHIFT;
                end
              end
            end
            ACT_DEL_FIRST, ACT_DEL_LAST, ACT_DEL_AT: begin
              if (empty) begin
                stat_d = ST_EMPTY;
              end else if (action_i == ACT_DEL_AT && !del_pos_ok) begin
                stat_d = ST_BADPOS;
              end else begin
                ins_d = 1'b0;
                if (action_i == ACT_DEL_FIRST) begin
                  idx_d = '0;
                end else if (action_i == ACT_DEL_LAST) begin
                  idx_d = cnt_m1;
                end else begin
                  idx_d = pos_idx;
                end
                if (idx_d == cnt_m1) begin
                  cnt_d = cnt_q - CNT_W'(1);
                end else begin
                  // Move the tail down by one, from the slot after to the end.
                  ptr_d   = idx_d + ADDR_W'(1);
                  stop_d  = cnt_m1;
                  more_d  = 1'b1;
                  wv_d    = 1'b0;
                  state_d = S_SHIFT;
                end
              end
            end
            ACT_READ_ALL: begin
              if (empty) begin
                stat_d = ST_EMPTY;
              end else begin
                ptr_d   = '0;
                state_d = S_RREQ;
              end
            end
            default: ;
          endcase
        end
      end

      S_SHIFT: begin
        mem_o.we    = wv_q;
        mem_o.waddr = wa_q;
        mem_o.wdata = rdata_i;
        if (more_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = ptr_q;
          wa_d        = ins_q ? ptr_inc : ptr_dec;
          wv_d        = 1'b1;
          if (ptr_q == stop_q) begin
            more_d = 1'b0;
          end else begin
            ptr_d = ins_q ? ptr_dec : ptr_inc;
          end
        end else begin
          wv_d = 1'b0;
          if (ins_q) begin
            state_d = S_PUT;
          end else begin
            cnt_d   = cnt_q - CNT_W'(1);
            state_d = S_EMIT;
          end
        end
      end

      S_PUT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = idx_q;
        mem_o.wdata = val_q;
        cnt_d       = cnt_q + CNT_W'(1);
        state_d     = S_EMIT;
      end

      S_EMIT: begin
        if (out_free_i) begin
          res_o.vld    = 1'b1;
          res_o.status = stat_q;
          res_o.count  = COUNT_W'(cnt_q);
          res_o.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_RREQ: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = ptr_q;
        state_d     = S_RDATA;
      end

      S_RDATA: begin
        if (out_free_i) begin
          res_o.vld     = 1'b1;
          res_o.status  = ST_OK;
          res_o.element = rdata_i;
          res_o.count   = COUNT_W'(cnt_q);
          res_o.last    = rd_last;
          if (rd_last) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_inc;
            state_d = S_RREQ;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      more_q  <= 1'b0;
      wv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      more_q  <= more_d;
      wv_q    <= wv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    stop_q <= stop_d;
    wa_q   <= wa_d;
    idx_q  <= idx_d;
    ins_q  <= ins_d;
    val_q  <= val_d;
    stat_q <= stat_d;
  end

endmodule

@@ rtl/core/positional_list_engine.sv @@
// Top level of the positional list engine: sequencer, element store and
// output register. Depends on ple_pkg, ple_ctrl, ple_store and the macros.
//
//  channel  direction  payload                          handshake
//  in       to block   action_i, value_i, position_i    in_valid_i / in_ready_o
//  out      from block status_o, element_o, count_o,    out_valid_o / out_ready_i
//                      last_o
//
// Sequence: a request is taken only while the sequencer is idle. A rejected
// request, an ignored action or a delete that needs no move goes straight to
// its result; an insert writes the new element, after moving the tail up by
// one when it must, and a delete that needs a move shifts the tail down first.
// read_all reads each element from the store and then issues it as a result.
// Reset clears the count, the sequencer state and out_valid_o, not the store.
// A stalled result is held in the output register while the next request
// is taken and worked on; the sequencer waits only to hand over a result.
`include "positional_list_engine_macros.svh"

module positional_list_engine import ple_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ACT_W-1:0]   action_i,
  input  data_t              value_i,
  input  logic [POS_W-1:0]   position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stat_t              status_o,
  output data_t              element_o,
  output logic [COUNT_W-1:0] count_o,
  output logic               last_o
);

  mem_req_t mem_req;
  data_t    rdata;
  res_t     res;
  cnt_t     cnt;
  logic     out_free;

  logic               out_vld_q;
  stat_t              status_q;
  data_t              element_q;
  logic [COUNT_W-1:0] count_q;
  logic               last_q;

  // The output register can take a new request result when empty or draining.
  assign out_free = !out_vld_q || out_ready_i;

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .value_i    (value_i),
    .position_i (position_i),
    .out_free_i (out_free),
    .res_o      (res),
    .mem_o      (mem_req),
    .rdata_i    (rdata),
    .cnt_o      (cnt)
  );

  ple_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Output register: load a new result, drop the old one once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res.vld) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Hold the payload until the next load.
  always_ff @(posedge clk_i) begin
    if (res.vld) begin
      status_q  <= res.status;
      element_q <= res.element;
      count_q   <= res.count;
      last_q    <= res.last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign count_o     = count_q;
  assign last_o      = last_q;

  `PLE_ASSERT_ALWAYS(a_cnt_in_range, !rst_ni || (cnt <= CNT_W'(CAPACITY)), "count beyond capacity")
  `PLE_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  `PLE_ASSERT(a_load_when_free, res.vld |-> (!out_valid_o || out_ready_i), "result overwrites held result")

endmodule
